// ===== sv/pulse_rate_window_meter_core_macros.svh =====
// assertion macros for the pulse rate window meter
// used by the top level only; expects clk and rst in scope
`ifndef PULSE_RATE_WINDOW_METER_CORE_MACROS_SVH
`define PULSE_RATE_WINDOW_METER_CORE_MACROS_SVH

// property must hold at every edge outside reset
`define PRWM_ASSERT_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define PRWM_ASSERT_NEVER(label, expr, msg) \
  `PRWM_ASSERT_HOLDS(label, !(expr), msg)

`endif

// ===== sv/prwm_pkg.sv =====
// shared types and constants for the pulse rate window meter
// no dependencies; imported by prwm_mul and the top level
`default_nettype none

package prwm_pkg;

  localparam int MAX_BEATS = 255;
  localparam int CNT_W     = $clog2(MAX_BEATS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BEATS);

  localparam int RATE_W  = 14;
  localparam int SCALE_W = 6;
  localparam int THR_W   = 7;
  localparam int CFG_W   = 7;
  localparam int PROD_W  = RATE_W + THR_W;

  localparam logic [RATE_W-1:0] RATE_MAX  = '1;
  localparam logic [THR_W-1:0]  PCT_SCALE = THR_W'(100);

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(20);
  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(15);

  localparam logic [0:0] REG_RATE_SCALE       = 1'b0;
  localparam logic [0:0] REG_CHANGE_THRESHOLD = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RATE,
    S_DIFF,
    S_CMP
  } state_t;

endpackage

`default_nettype wire

// ===== sv/pulse_rate_window_meter_core.sv =====
// pulse rate window meter: counts beats over a window and reports the rate
// input word: beat_level, window_end (valid/ready); output word: pulse_rate,
// rate_updated (valid/ready); config: cfg_we/cfg_index/cfg_data write port.
// a word without window_end is taken and gives no result; the block stays
// ready for the next word in the following cycle.
// a word with window_end starts a four step sequence on the one shared
// multiplier: count times scale in the accept cycle, then difference times
// 100, threshold times stored rate, and the compare. in_ready is low in the
// S_RATE, S_DIFF and S_CMP states, and the result word is loaded into the
// output register in the compare step once that register is free.
// the percent test is done as diff*100 >= threshold*stored, so no divider.
// the result sits in an output register; further words without window_end
// keep being taken while it waits. a second window end waits in the compare
// step until the output register is free, holding in_ready low.
// reset clears the count, the armed flag, the stored rate and the output
// valid, and loads scale 20 and threshold 15.
`default_nettype none

module pulse_rate_window_meter_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         beat_level,
  input  logic                         window_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [prwm_pkg::RATE_W-1:0]  pulse_rate,
  output logic                         rate_updated,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [prwm_pkg::CFG_W-1:0]   cfg_data
);
  import prwm_pkg::*;

  state_t state, state_next;

  logic [SCALE_W-1:0] rate_scale;
  logic [THR_W-1:0]   change_threshold_pct;
  logic [CNT_W-1:0]   beat_count;
  logic               beat_armed;
  logic [RATE_W-1:0]  stored_rate;
  logic [RATE_W-1:0]  rate_new;
  logic [PROD_W-1:0]  lhs;

  logic [CNT_W-1:0]   count_upd;
  logic               armed_upd;
  logic               in_fire;
  logic               out_free;
  logic               load_out;
  logic               replace;
  logic [RATE_W-1:0]  rate_sat;
  logic [RATE_W-1:0]  diff;
  logic [RATE_W-1:0]  mul_a;
  logic [THR_W-1:0]   mul_b;
  logic [PROD_W-1:0]  product;

  prwm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (product)
  );

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // beat detection on the incoming sample
  always_comb begin
    count_upd = beat_count;
    armed_upd = beat_armed;
    if (beat_level) begin
      if (!beat_armed) begin
        if (beat_count < CNT_MAX) begin
          count_upd = beat_count + CNT_W'(1);
        end
        armed_upd = 1'b1;
      end
    end else begin
      armed_upd = 1'b0;
    end
  end

  always_comb begin
    rate_sat = (product > PROD_W'(RATE_MAX)) ? RATE_MAX : product[RATE_W-1:0];
    diff     = (stored_rate >= rate_sat) ? (stored_rate - rate_sat)
                                         : (rate_sat - stored_rate);
    replace  = (stored_rate == '0) || (lhs >= product);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && window_end) begin
          state_next = S_RATE;
        end
      end
      S_RATE: state_next = S_DIFF;
      S_DIFF: state_next = S_CMP;
      S_CMP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  // sequencer outputs and multiplier operand select
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    mul_a    = stored_rate;
    mul_b    = change_threshold_pct;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        mul_a    = RATE_W'(count_upd);
        mul_b    = THR_W'(rate_scale);
      end
      S_RATE: begin
        mul_a = diff;
        mul_b = PCT_SCALE;
      end
      S_DIFF: begin
        mul_a = stored_rate;
        mul_b = change_threshold_pct;
      end
      S_CMP: begin
        load_out = out_free;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      rate_scale           <= SCALE_RESET;
      change_threshold_pct <= THR_RESET;
      beat_count           <= '0;
      beat_armed           <= 1'b0;
      stored_rate          <= '0;
      out_valid            <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RATE_SCALE:       rate_scale <= cfg_data[SCALE_W-1:0];
          REG_CHANGE_THRESHOLD: change_threshold_pct <= cfg_data[THR_W-1:0];
        endcase
      end
      if (in_fire) begin
        if (window_end) begin
          beat_count <= '0;
          beat_armed <= 1'b0;
        end else begin
          beat_count <= count_upd;
          beat_armed <= armed_upd;
        end
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
        if (replace) begin
          stored_rate <= rate_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RATE) begin
      rate_new <= rate_sat;
    end
    if (state == S_DIFF) begin
      lhs <= product;
    end
    if (load_out) begin
      pulse_rate   <= replace ? rate_new : stored_rate;
      rate_updated <= replace;
    end
  end

`include "pulse_rate_window_meter_core_macros.svh"

  `PRWM_ASSERT_HOLDS(a_window_seq, in_fire && window_end |-> ##3 (state == S_CMP), "window steps")
  `PRWM_ASSERT_HOLDS(a_plain_word, in_fire && !window_end |=> (state == S_IDLE), "plain word")
  `PRWM_ASSERT_NEVER(a_count_max, beat_count > CNT_MAX, "beat count above limit")

endmodule

`default_nettype wire

// ===== sv/prwm_mul.sv =====
// shared 14x7 multiplier with a registered product
// depends on prwm_pkg for operand and product widths
`default_nettype none

module prwm_mul (
  input  logic                          clk,
  input  logic [prwm_pkg::RATE_W-1:0]   a,
  input  logic [prwm_pkg::THR_W-1:0]    b,
  output logic [prwm_pkg::PROD_W-1:0]   p
);
  import prwm_pkg::*;

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

`default_nettype wire
